// ----- design/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants, S-box tables and GF(2^8) helpers for the AES core
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned RowCount = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_LOAD,
        ST_FIRST,
        ST_ROUND
    } aes_state_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  row;
        logic [1:0]  lane;
        logic [31:0] data;
    } key_wr_t;

    localparam logic [1:0] KL_128 = 2'd0;
    localparam logic [1:0] KL_192 = 2'd1;

    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_01     = 3'd1;
    localparam logic [2:0] CFG_KEY_23     = 3'd2;
    localparam logic [2:0] CFG_KEY_45     = 3'd3;
    localparam logic [2:0] CFG_KEY_67     = 3'd4;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] DEC_SBOX [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] mul3(input logic [7:0] x);
        return xt(x) ^ x;
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] x);
        return xt(xt(xt(x))) ^ x;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] x);
        return xt(xt(xt(x))) ^ xt(x) ^ x;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] x);
        return xt(xt(xt(x))) ^ xt(xt(x)) ^ x;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] x);
        return xt(xt(xt(x))) ^ xt(xt(x)) ^ xt(x);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [3:0] rounds_of(input logic [1:0] kl);
        logic [3:0] n;
        unique case (kl)
            KL_128:  n = 4'd10;
            KL_192:  n = 4'd12;
            default: n = 4'd14;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] key_words_of(input logic [1:0] kl);
        logic [3:0] n;
        unique case (kl)
            KL_128:  n = 4'd4;
            KL_192:  n = 4'd6;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

// ----- design/aes_key_expand.sv -----
// ----------------------------------------------------------------------------
// aes_key_expand
// Word-serial key schedule: one round-key word per cycle into the key memory
// ----------------------------------------------------------------------------
module aes_key_expand
    import aes_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [1:0]     key_length,
    input  logic [255:0]   key_bits,
    output key_wr_t        wr,
    output logic           done
);

    logic        busy_reg;
    logic [5:0]  idx_reg;
    logic [2:0]  kmod_reg;
    logic [7:0]  rcon_reg;
    logic [31:0] win_reg [8];

    logic [3:0]  nk;
    logic [5:0]  total;
    logic [2:0]  far;
    logic        loading;
    logic [31:0] key_word;
    logic [31:0] last_w;
    logic [31:0] word_next;

    always_comb
    begin
        nk       = key_words_of(key_length);
        total    = 6'({nk, 2'b00} + 6'd28);
        far      = 3'(nk - 4'd1);
        loading  = idx_reg < {2'b00, nk};
        key_word = key_bits[8'd255 - {idx_reg[2:0], 5'b00000} -: 32];
        last_w   = win_reg[0];
        if (loading)
        begin
            word_next = key_word;
        end
        else if (kmod_reg == 3'd0)
        begin
            word_next = win_reg[far] ^ sub_word({last_w[23:0], last_w[31:24]})
                        ^ {rcon_reg, 24'h000000};
        end
        else if (nk == 4'd8 && kmod_reg == 3'd4)
        begin
            word_next = win_reg[far] ^ sub_word(last_w);
        end
        else
        begin
            word_next = win_reg[far] ^ last_w;
        end
        wr.en   = busy_reg;
        wr.row  = idx_reg[5:2];
        wr.lane = idx_reg[1:0];
        wr.data = word_next;
        done    = busy_reg && (idx_reg == total - 6'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            kmod_reg <= '0;
            rcon_reg <= 8'h01;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            kmod_reg <= '0;
            rcon_reg <= 8'h01;
        end
        else if (busy_reg)
        begin
            idx_reg  <= idx_reg + 6'd1;
            kmod_reg <= (kmod_reg == far) ? 3'd0 : kmod_reg + 3'd1;
            if (!loading && kmod_reg == 3'd0)
            begin
                rcon_reg <= xt(rcon_reg);
            end
            if (done)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            win_reg[0] <= word_next;
            for (int j = 1; j < 8; j++)
            begin
                win_reg[j] <= win_reg[j-1];
            end
        end
    end

endmodule

// ----- design/aes_key_mem.sv -----
// ----------------------------------------------------------------------------
// aes_key_mem
// Round-key memory, one 128-bit row per round, word-lane writes, registered read
// ----------------------------------------------------------------------------
module aes_key_mem
    import aes_pkg::*;
(
    input  logic           clk,
    input  key_wr_t        wr,
    input  logic [3:0]     rd_row,
    output logic [127:0]   rd_data
);

    logic [127:0] mem [RowCount];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.row][{~wr.lane, 5'b00000} +: 32] <= wr.data;
        end
        rd_data <= mem[rd_row];
    end

endmodule

// ----- design/aes_round.sv -----
// ----------------------------------------------------------------------------
// aes_round
// One full cipher or inverse-cipher round on the 128-bit state
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
(
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         dec,
    input  logic         last,
    output logic [127:0] state_out
);

    logic [7:0] s   [16];
    logic [7:0] k   [16];
    logic [7:0] esr [16];
    logic [7:0] emc [16];
    logic [7:0] dsb [16];
    logic [7:0] dak [16];
    logic [7:0] dmc [16];
    logic [7:0] res [16];

    always_comb
    begin
        for (int n = 0; n < 16; n++)
        begin
            s[n] = state_in[127 - 8*n -: 8];
            k[n] = round_key[127 - 8*n -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                esr[4*c + r] = SBOX[s[4*((c + r) & 3) + r]];
                dsb[4*c + r] = DEC_SBOX[s[4*((c + 4 - r) & 3) + r]];
            end
        end
        for (int n = 0; n < 16; n++)
        begin
            dak[n] = dsb[n] ^ k[n];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                emc[4*c + r] = xt(esr[4*c + r]) ^ mul3(esr[4*c + ((r + 1) & 3)])
                               ^ esr[4*c + ((r + 2) & 3)] ^ esr[4*c + ((r + 3) & 3)];
                dmc[4*c + r] = mul14(dak[4*c + r]) ^ mul11(dak[4*c + ((r + 1) & 3)])
                               ^ mul13(dak[4*c + ((r + 2) & 3)])
                               ^ mul9(dak[4*c + ((r + 3) & 3)]);
            end
        end
        for (int n = 0; n < 16; n++)
        begin
            if (dec)
            begin
                res[n] = last ? dak[n] : dmc[n];
            end
            else
            begin
                res[n] = (last ? esr[n] : emc[n]) ^ k[n];
            end
            state_out[127 - 8*n -: 8] = res[n];
        end
    end

endmodule

// ----- design/aes_block_cipher_core.sv -----
// ----------------------------------------------------------------------------
// aes_block_cipher_core
// AES-128/192/256 encrypt and decrypt, iterative, one round per cycle
// ----------------------------------------------------------------------------
// the key schedule is expanded into the key memory on the first block after reset
// or after any key length or key register write; the last round is held while an
// earlier result waits for out_ready; a new block is accepted only in the idle
// state, after the previous block's result has been loaded
// reset clears control state and key registers; key memory is not cleared
module aes_block_cipher_core
    import aes_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         kind,
    input  logic [63:0]  block_high,
    input  logic [63:0]  block_low,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  result_high,
    output logic [63:0]  result_low
);

    aes_state_t   fsm_reg, fsm_next;
    logic [1:0]   kl_reg;
    logic [63:0]  key01_reg, key23_reg, key45_reg, key67_reg;
    logic         keys_ready_reg;
    logic         dec_reg;
    logic [127:0] data_reg, data_next;
    logic [3:0]   row_reg, row_next;
    logic [127:0] res_reg;
    logic         out_valid_reg;

    logic         accept;
    logic         exp_start;
    logic         exp_done;
    logic         load_result;
    logic         last;
    logic [3:0]   nr;
    logic [127:0] rd_data;
    logic [127:0] round_out;
    key_wr_t      key_wr;

    aes_key_expand u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (exp_start),
        .key_length (kl_reg),
        .key_bits   ({key01_reg, key23_reg, key45_reg, key67_reg}),
        .wr         (key_wr),
        .done       (exp_done)
    );

    aes_key_mem u_mem (
        .clk     (clk),
        .wr      (key_wr),
        .rd_row  (row_next),
        .rd_data (rd_data)
    );

    aes_round u_round (
        .state_in  (data_reg),
        .round_key (rd_data),
        .dec       (dec_reg),
        .last      (last),
        .state_out (round_out)
    );

    always_comb
    begin
        nr          = rounds_of(kl_reg);
        in_ready    = (fsm_reg == ST_IDLE);
        accept      = in_valid && in_ready;
        last        = dec_reg ? (row_reg == 4'd0) : (row_reg == nr);
        fsm_next    = fsm_reg;
        row_next    = row_reg;
        data_next   = data_reg;
        exp_start   = 1'b0;
        load_result = 1'b0;
        unique case (fsm_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next = {block_high, block_low};
                    exp_start = !keys_ready_reg;
                    fsm_next  = keys_ready_reg ? ST_LOAD : ST_EXPAND;
                end
            end
            ST_EXPAND:
            begin
                if (exp_done)
                begin
                    fsm_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                row_next = dec_reg ? nr : 4'd0;
                fsm_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                data_next = data_reg ^ rd_data;
                row_next  = dec_reg ? nr - 4'd1 : 4'd1;
                fsm_next  = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (last)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        load_result = 1'b1;
                        fsm_next    = ST_IDLE;
                    end
                end
                else
                begin
                    data_next = round_out;
                    row_next  = dec_reg ? row_reg - 4'd1 : row_reg + 4'd1;
                end
            end
            default:
            begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= ST_IDLE;
            kl_reg         <= KL_128;
            key01_reg      <= '0;
            key23_reg      <= '0;
            key45_reg      <= '0;
            key67_reg      <= '0;
            keys_ready_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            row_reg        <= '0;
        end
        else
        begin
            fsm_reg <= fsm_next;
            row_reg <= row_next;
            if (exp_done)
            begin
                keys_ready_reg <= 1'b1;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_KEY_LENGTH: kl_reg    <= cfg_data[1:0];
                    CFG_KEY_01:     key01_reg <= cfg_data;
                    CFG_KEY_23:     key23_reg <= cfg_data;
                    CFG_KEY_45:     key45_reg <= cfg_data;
                    CFG_KEY_67:     key67_reg <= cfg_data;
                    default:        ;
                endcase
                if (cfg_index <= CFG_KEY_67)
                begin
                    keys_ready_reg <= 1'b0;
                end
            end
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (accept)
        begin
            dec_reg <= kind;
        end
        if (load_result)
        begin
            res_reg <= round_out;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_high = res_reg[127:64];
    assign result_low  = res_reg[63:0];

    a_keys_before_rounds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_FIRST || fsm_reg == ST_ROUND) |-> keys_ready_reg
    ) else $error("round started without a built key schedule");

    a_cfg_drops_keys: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index <= CFG_KEY_67) |=> !keys_ready_reg
    ) else $error("key write did not invalidate schedule");

    a_row_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_ROUND) |-> (row_reg <= nr)
    ) else $error("round key row out of range");

    a_no_result_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_result
    ) else $error("pending result overwritten");

endmodule

// ----- verif/aes_block_cipher_core_test.sv -----
// ----------------------------------------------------------------------------
// aes_block_cipher_core_test
// Checks the AES core against a behavioral cipher model across key lengths,
// key values, both directions and random handshake idling, with scoreboarding
// ----------------------------------------------------------------------------
module aes_block_cipher_core_test
    import aes_pkg::*;
();

    typedef struct {
        logic        kind;
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_req_t;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_blk_t;

    localparam logic DIR_ENC = 1'b0;
    localparam logic DIR_DEC = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    aes_block_cipher_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .block_high(block_high), .block_low(block_low),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_high(result_high), .result_low(result_low)
    );

    // cipher model state
    logic [1:0]  key_len_reg;
    logic [63:0] key_reg [4];
    logic [31:0] sched [60];

    cipher_req_t pending_blocks[$];
    cipher_blk_t expected_blocks[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold;
    int          hold_requests;
    int          hold_served;
    bit          sender_pause;
    int          mismatches = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [7:0] gmul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = gmul2(a);
        end
        return p;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] a);
        logic [7:0] r;
        logic [7:0] base;
        r = 8'h01;
        base = a;
        for (int e = 254; e != 0; e >>= 1)
        begin
            if (e & 1)
                r = gmul(r, base);
            base = gmul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    function automatic logic [7:0] fwd_sub(input logic [7:0] x);
        logic [7:0] b;
        b = ginv(x);
        return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    endfunction

    function automatic logic [7:0] rev_sub(input logic [7:0] s);
        return ginv(rol8(s, 1) ^ rol8(s, 3) ^ rol8(s, 6) ^ 8'h05);
    endfunction

    function automatic logic [31:0] sub4(input logic [31:0] w);
        return {fwd_sub(w[31:24]), fwd_sub(w[23:16]), fwd_sub(w[15:8]), fwd_sub(w[7:0])};
    endfunction

    function automatic int key_word_count();
        return (key_len_reg == 2'd0) ? 4 : (key_len_reg == 2'd1) ? 6 : 8;
    endfunction

    task automatic build_schedule();
        int nk;
        logic [31:0] t;
        logic [7:0] rc;
        nk = key_word_count();
        rc = 8'h01;
        for (int i = 0; i < nk; i++)
            sched[i] = (i & 1) ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
        for (int i = nk; i < 4 * (nk + 7); i++)
        begin
            t = sched[i - 1];
            if (i % nk == 0)
            begin
                t = sub4({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gmul2(rc);
            end
            else if (nk > 6 && i % nk == 4)
                t = sub4(t);
            sched[i] = sched[i - nk] ^ t;
        end
    endtask

    function automatic void add_key(inout logic [7:0] s[16], input int rnd);
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                s[4 * c + r] ^= sched[4 * rnd + c][31 - 8 * r -: 8];
    endfunction

    function automatic void sub_all(inout logic [7:0] s[16], input logic inv);
        for (int i = 0; i < 16; i++)
            s[i] = inv ? rev_sub(s[i]) : fwd_sub(s[i]);
    endfunction

    function automatic void shift_all(inout logic [7:0] s[16], input logic inv);
        logic [7:0] t[16];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                if (inv)
                    t[4 * ((c + r) % 4) + r] = s[4 * c + r];
                else
                    t[4 * c + r] = s[4 * ((c + r) % 4) + r];
        s = t;
    endfunction

    function automatic void mix_all(inout logic [7:0] s[16], input logic inv);
        logic [7:0] m[4];
        logic [7:0] t[4];
        if (inv)
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[r] = 8'h00;
                for (int k = 0; k < 4; k++)
                    t[r] ^= gmul(s[4 * c + k], m[(k + 4 - r) % 4]);
            end
            for (int r = 0; r < 4; r++)
                s[4 * c + r] = t[r];
        end
    endfunction

    function automatic cipher_blk_t cipher_block(input cipher_req_t req);
        logic [7:0] s[16];
        cipher_blk_t res;
        int nr;
        nr = key_word_count() + 6;
        for (int i = 0; i < 8; i++)
        begin
            s[i] = req.hi[63 - 8 * i -: 8];
            s[8 + i] = req.lo[63 - 8 * i -: 8];
        end
        if (req.kind == DIR_ENC)
        begin
            add_key(s, 0);
            for (int rnd = 1; rnd < nr; rnd++)
            begin
                sub_all(s, 1'b0);
                shift_all(s, 1'b0);
                mix_all(s, 1'b0);
                add_key(s, rnd);
            end
            sub_all(s, 1'b0);
            shift_all(s, 1'b0);
            add_key(s, nr);
        end
        else
        begin
            add_key(s, nr);
            for (int rnd = nr - 1; rnd > 0; rnd--)
            begin
                shift_all(s, 1'b1);
                sub_all(s, 1'b1);
                add_key(s, rnd);
                mix_all(s, 1'b1);
            end
            shift_all(s, 1'b1);
            sub_all(s, 1'b1);
            add_key(s, 0);
        end
        for (int i = 0; i < 8; i++)
        begin
            res.hi[63 - 8 * i -: 8] = s[i];
            res.lo[63 - 8 * i -: 8] = s[8 + i];
        end
        return res;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 1'b0;
            block_high <= '0;
            block_low <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_blocks.size() != 0 && !sender_pause &&
                $urandom_range(99) >= send_idle_pct)
            begin
                cipher_req_t req;
                req = pending_blocks.pop_front();
                expected_blocks.insert(expected_blocks.size(), cipher_block(req));
                in_valid <= 1'b1;
                kind <= req.kind;
                block_high <= req.hi;
                block_low <= req.lo;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_hold <= 0;
            hold_served <= 0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_requests;
            recv_hold <= 300;
            out_ready <= 1'b0;
        end
        else if (recv_hold > 0)
        begin
            recv_hold <= recv_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_blocks.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer %h %h", result_high, result_low);
            end
            else
            begin
                cipher_blk_t want;
                want = expected_blocks.pop_front();
                if (want.hi !== result_high || want.lo !== result_low)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h %h got %h %h",
                                 want.hi, want.lo, result_high, result_low);
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_KEY_LENGTH)
            key_len_reg = val[1:0];
        else if (idx <= CFG_KEY_67)
            key_reg[idx - 1] = val;
        build_schedule();
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0 || expected_blocks.size() != 0 || in_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_word_edge();
        case ($urandom_range(5))
            0: return 64'h0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    task automatic queue_block(input logic k, input logic [63:0] h, input logic [63:0] l);
        cipher_req_t req;
        req.kind = k;
        req.hi = h;
        req.lo = l;
        pending_blocks.insert(pending_blocks.size(), req);
    endtask

    task automatic new_key(input logic [1:0] kl, input bit edge_vals);
        write_reg(CFG_KEY_LENGTH, {62'h0, kl});
        for (int r = 1; r <= 4; r++)
            write_reg(3'(r), edge_vals ? rand_word_edge() : rand64());
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_KEY_LENGTH;
        cfg_data = '0;
        send_idle_pct = 24;
        recv_idle_pct = 72;
        hold_requests = 0;
        sender_pause = 1'b0;
        key_len_reg = KL_128;
        for (int i = 0; i < 4; i++)
            key_reg[i] = '0;
        build_schedule();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: all-zero 128-bit, then FIPS-197 appendix C vectors
        queue_block(DIR_ENC, 64'h0, 64'h0);
        queue_block(DIR_DEC, '1, '1);
        drain();
        write_reg(CFG_KEY_01, 64'h0001020304050607);
        write_reg(CFG_KEY_23, 64'h08090a0b0c0d0e0f);
        write_reg(CFG_KEY_45, 64'h1011121314151617);
        write_reg(CFG_KEY_67, 64'h18191a1b1c1d1e1f);
        write_reg(3'd5, '1);
        for (int kl = 0; kl < 4; kl++)
        begin
            write_reg(CFG_KEY_LENGTH, 64'(kl));
            queue_block(DIR_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
            queue_block(DIR_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
            queue_block(DIR_ENC, '1, 64'h0);
            queue_block(DIR_DEC, 64'h0, '1);
            drain();
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 72 : 0;
            recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 24 : 0;
            for (int grp = 0; grp < 10; grp++)
            begin
                new_key(2'($urandom_range(3)), grp < 3);
                for (int n = 0; n < 53; n++)
                    queue_block(1'($urandom_range(1)), rand_word_edge(), rand_word_edge());
                if (grp == 4)
                    hold_requests++;
                if (grp == 6)
                begin
                    while (pending_blocks.size() > 20)
                        @(posedge clk);
                    sender_pause = 1'b1;
                    while (expected_blocks.size() != 0 || in_valid)
                        @(posedge clk);
                    sender_pause = 1'b0;
                end
                drain();
            end
        end

        if (mismatches == 0 && expected_blocks.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
